### design/rta_pkg.sv
// Package for the rational time ALU: opcodes, widths, sequencer states
// and the request and response structs shared by the core and its serial arithmetic unit.
// Depends on nothing.
package rta_pkg;

  localparam int unsigned VW = 64;
  localparam int unsigned SW = 31;
  localparam int unsigned RSW = 62;
  localparam int unsigned CW = 7;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_LT  = 3'd2,
    OP_GT  = 3'd3,
    OP_EQ  = 3'd4,
    OP_NE  = 3'd5,
    OP_RSC = 3'd6,
    OP_NOP = 3'd7
  } op_t;

  // Serial unit job codes.
  typedef enum logic [1:0] {
    JOB_MUL = 2'd0,
    JOB_DIV = 2'd1,
    JOB_MOD = 2'd2
  } job_t;

  typedef struct packed {
    logic        start;
    job_t        job;
    logic [VW-1:0] x;
    logic [VW-1:0] y;
  } ser_req_t;

  typedef struct packed {
    logic        done;
    logic [VW-1:0] q;
    logic [VW-1:0] r;
  } ser_rsp_t;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_GCD    = 14'b00000000000010,
    S_GCDW   = 14'b00000000000100,
    S_LDIV   = 14'b00000000001000,
    S_LDIVW  = 14'b00000000010000,
    S_LMUL   = 14'b00000000100000,
    S_LMULW  = 14'b00000001000000,
    S_XMUL   = 14'b00000010000000,
    S_XMULW  = 14'b00000100000000,
    S_YMUL   = 14'b00001000000000,
    S_YMULW  = 14'b00010000000000,
    S_DONE   = 14'b00100000000000,
    S_RDIV   = 14'b01000000000000,
    S_OUT    = 14'b10000000000000
  } state_t;

endpackage

### design/rta_serial.sv
// Bit-serial 64-bit multiplier and unsigned divider sharing one shift datapath.
// Depends on rta_pkg.
module rta_serial (
  input  logic              clk,
  input  logic              rst,
  input  rta_pkg::ser_req_t req,
  output rta_pkg::ser_rsp_t rsp
);

  logic                      busy;
  rta_pkg::job_t             job;
  logic [rta_pkg::CW-1:0]    count;
  logic [rta_pkg::VW-1:0]    acc;
  logic [rta_pkg::VW-1:0]    sh;
  logic [rta_pkg::VW-1:0]    dv;
  logic [rta_pkg::VW:0]      rem_try;
  logic [rta_pkg::VW:0]      rem_sub;
  logic                      done;

  // One restoring-division step: shift in the next dividend bit, try subtract.
  assign rem_try = {acc, sh[rta_pkg::VW-1]};
  assign rem_sub = rem_try - {1'b0, dv};

  // Multiply takes one multiplier bit per cycle, divide one quotient bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        job   <= req.job;
        count <= '0;
        acc   <= '0;
        sh    <= req.x;
        dv    <= req.y;
      end else if (busy) begin
        if (job == rta_pkg::JOB_MUL) begin
          if (sh[0]) acc <= acc + dv;
          sh <= sh >> 1;
          dv <= dv << 1;
        end else begin
          if (!rem_sub[rta_pkg::VW]) begin
            acc <= rem_sub[rta_pkg::VW-1:0];
          end else begin
            acc <= rem_try[rta_pkg::VW-1:0];
          end
          sh <= {sh[rta_pkg::VW-2:0], ~rem_sub[rta_pkg::VW]};
        end
        count <= count + 1'b1;
        if (count == rta_pkg::CW'(rta_pkg::VW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // For multiply the product sits in acc; for divide quotient in sh.
  assign rsp.done = done;
  assign rsp.q = (job == rta_pkg::JOB_MUL) ? acc : sh;
  assign rsp.r = acc;

  a_done_one_cycle: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held more than one cycle");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    busy && !done |-> !req.start) else $error("start while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(busy)) else $error("done without work");

endmodule

### design/rational_time_alu_core.sv
// Top level of the rational time ALU: stream ports, operation sequencer
// and output register. Depends on rta_pkg and rta_serial.
// Equal scales and cmd 7 skip the bit-serial unit, and rescale to zero goes straight
// to the output; rescale uses a multiply and a divide, unequal compares two multiplies,
// and unequal add/sub one modulo per Euclid step, then two divides and three multiplies.
// One item at a time; the next input can be taken in the cycle after the output transfer.
module rational_time_alu_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // s_tdata fields from bit 0: cmd[2:0], a_value[63:0], a_scale[30:0],
  // b_value[63:0], b_scale[30:0], new_scale[31:0], zero fill to 232 bits
  input  logic [231:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // m_tdata fields from bit 0: result_value[63:0], result_scale[61:0],
  // compare_true, zero fill to 128 bits
  output logic [127:0] m_tdata
);

  rta_pkg::state_t   state;
  rta_pkg::op_t      op;
  logic [63:0]       av, bv, gx, gy, sc, xm, ym, rv, p;
  logic [30:0]       as, bs;
  logic [61:0]       rs;
  logic              ct;
  rta_pkg::ser_req_t req;
  rta_pkg::ser_rsp_t rsp;
  logic [30:0]       in_as, in_bs;
  logic              lt_w, gt_w, eq_w;

  rta_serial u_ser (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  assign s_tready = (state == rta_pkg::S_IDLE);
  assign in_as = (s_tdata[97:67] == '0) ? 31'd1 : s_tdata[97:67];
  assign in_bs = (s_tdata[192:162] == '0) ? 31'd1 : s_tdata[192:162];

  // Signed compare of the (possibly cross-multiplied) counts in xm and ym.
  assign lt_w = $signed(xm) < $signed(ym);
  assign gt_w = $signed(ym) < $signed(xm);
  assign eq_w = (xm == ym);

  // Sequencer for gcd, lcm and scaled operands, compares, rescale and the output.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= rta_pkg::S_IDLE;
      m_tvalid <= 1'b0;
      req.start <= 1'b0;
    end else begin
      req.start <= 1'b0;
      case (state)
        rta_pkg::S_IDLE: begin
          if (s_tvalid) begin
            op <= rta_pkg::op_t'(s_tdata[2:0]);
            av <= s_tdata[66:3];
            as <= in_as;
            bv <= s_tdata[161:98];
            bs <= in_bs;
            gx <= {33'd0, in_as};
            gy <= {33'd0, in_bs};
            xm <= s_tdata[66:3];
            ym <= s_tdata[161:98];
            sc <= {33'd0, in_as};
            rv <= '0;
            rs <= '0;
            ct <= 1'b0;
            if (s_tdata[2:0] == rta_pkg::OP_RSC) begin
              if (s_tdata[224:193] == '0) begin
                state <= rta_pkg::S_OUT;
              end else begin
                req.start <= 1'b1;
                req.job <= rta_pkg::JOB_MUL;
                req.x <= s_tdata[66:3];
                req.y <= {{32{s_tdata[224]}}, s_tdata[224:193]};
                state <= rta_pkg::S_RDIV;
              end
            end else if (s_tdata[2:0] == rta_pkg::OP_NOP || in_as == in_bs) begin
              state <= rta_pkg::S_DONE;
            end else if (s_tdata[2:0] <= rta_pkg::OP_SUB) begin
              state <= rta_pkg::S_GCD;
            end else begin
              req.start <= 1'b1;
              req.job <= rta_pkg::JOB_MUL;
              req.x <= s_tdata[66:3];
              req.y <= {33'd0, in_bs};
              state <= rta_pkg::S_XMULW;
            end
          end
        end
        // Euclid: one modulo per step.
        rta_pkg::S_GCD: begin
          if (gy == '0) begin
            req.start <= 1'b1;
            req.job <= rta_pkg::JOB_DIV;
            req.x <= {33'd0, as};
            req.y <= gx;
            state <= rta_pkg::S_LDIVW;
          end else begin
            req.start <= 1'b1;
            req.job <= rta_pkg::JOB_MOD;
            req.x <= gx;
            req.y <= gy;
            state <= rta_pkg::S_GCDW;
          end
        end
        rta_pkg::S_GCDW: begin
          if (rsp.done) begin
            gx <= gy;
            gy <= rsp.r;
            state <= rta_pkg::S_GCD;
          end
        end
        rta_pkg::S_LDIVW: begin
          if (rsp.done) begin
            // as/g and bs/g, then bv*(as/g), av*(bs/g) and lcm = (as/g)*bs.
            sc <= rsp.q;
            req.start <= 1'b1;
            req.job <= rta_pkg::JOB_DIV;
            req.x <= {33'd0, bs};
            req.y <= gx;
            state <= rta_pkg::S_LMULW;
          end
        end
        rta_pkg::S_LMULW: begin
          if (rsp.done) begin
            gy <= rsp.q;
            req.start <= 1'b1;
            req.job <= rta_pkg::JOB_MUL;
            req.x <= bv;
            req.y <= sc;
            state <= rta_pkg::S_LDIV;
          end
        end
        rta_pkg::S_LDIV: begin
          if (rsp.done) begin
            ym <= rsp.q;
            req.start <= 1'b1;
            req.job <= rta_pkg::JOB_MUL;
            req.x <= av;
            req.y <= gy;
            state <= rta_pkg::S_LMUL;
          end
        end
        rta_pkg::S_LMUL: begin
          if (rsp.done) begin
            xm <= rsp.q;
            req.start <= 1'b1;
            req.job <= rta_pkg::JOB_MUL;
            req.x <= sc;
            req.y <= {33'd0, bs};
            state <= rta_pkg::S_YMULW;
          end
        end
        rta_pkg::S_YMULW: begin
          if (rsp.done) begin
            sc <= rsp.q;
            state <= rta_pkg::S_DONE;
          end
        end
        // Cross multiplication for compares.
        rta_pkg::S_XMULW: begin
          if (rsp.done) begin
            xm <= rsp.q;
            req.start <= 1'b1;
            req.job <= rta_pkg::JOB_MUL;
            req.x <= bv;
            req.y <= {33'd0, as};
            state <= rta_pkg::S_XMUL;
          end
        end
        rta_pkg::S_XMUL: begin
          if (rsp.done) begin
            ym <= rsp.q;
            state <= rta_pkg::S_DONE;
          end
        end
        rta_pkg::S_RDIV: begin
          if (rsp.done) begin
            p <= rsp.q;
            req.start <= 1'b1;
            req.job <= rta_pkg::JOB_DIV;
            req.x <= rsp.q[63] ? (64'd0 - rsp.q) : rsp.q;
            req.y <= {33'd0, as};
            state <= rta_pkg::S_YMUL;
          end
        end
        rta_pkg::S_YMUL: begin
          if (rsp.done) begin
            rv <= p[63] ? (64'd0 - rsp.q) : rsp.q;
            state <= rta_pkg::S_OUT;
          end
        end
        rta_pkg::S_DONE: begin
          case (op)
            rta_pkg::OP_ADD: begin rv <= xm + ym; rs <= sc[61:0]; end
            rta_pkg::OP_SUB: begin rv <= xm - ym; rs <= sc[61:0]; end
            rta_pkg::OP_LT:  ct <= lt_w;
            rta_pkg::OP_GT:  ct <= gt_w;
            rta_pkg::OP_EQ:  ct <= eq_w;
            rta_pkg::OP_NE:  ct <= !eq_w;
            default: ;
          endcase
          state <= rta_pkg::S_OUT;
        end
        rta_pkg::S_OUT: begin
          if (m_tvalid && m_tready) begin
            m_tvalid <= 1'b0;
            state <= rta_pkg::S_IDLE;
          end else begin
            m_tvalid <= 1'b1;
          end
        end
        default: state <= rta_pkg::S_IDLE;
      endcase
    end
  end

  assign m_tdata = {1'b0, ct, rs, rv};

  a_out_in_out_state: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> state == rta_pkg::S_OUT) else $error("result outside output state");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("input ready while result pending");
  a_cmp_no_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ct |-> rv == '0 && rs == '0) else $error("compare with value");

endmodule
